/* src/fmf_pkg.sv */
// Shared types and constants for the FIX message framer.
package fmf_pkg;

    localparam int unsigned LEN_W           = 21;
    localparam int unsigned MP_W            = 6;
    localparam int unsigned BEGIN_FIELD_MAX = 32;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] LENGTH_LIMIT  = LEN_W'(1048576);
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1 << 20);

    localparam logic [7:0] SOH_BYTE = 8'h01;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_BEGIN,
        PH_TAG9,
        PH_LENGTH,
        PH_BODY,
        PH_TRAILER
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NO_TAG9,
        ERR_BAD_LENGTH,
        ERR_NO_TAG10,
        ERR_CHECKSUM_DIGIT,
        ERR_NO_FINAL_SOH,
        ERR_BEGIN_LONG
    } err_t;

    // One input byte with its precomputed class bits.
    typedef struct packed {
        logic [7:0] data;
        logic       is_digit;
        logic       is_soh;
        logic [3:0] digit;
    } byte_class_t;

endpackage

/* src/fmf_front.sv */
// Input stage: takes a byte, classifies it and hands it to the queue.
module fmf_front
    import fmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        push,
    output byte_class_t push_item,
    input  logic        queue_full
);

    logic        valid_reg;
    logic        valid_next;
    byte_class_t item_reg;
    byte_class_t item_next;
    logic        accept;

    assign in_stall  = valid_reg && queue_full;
    assign accept    = in_valid && !in_stall;
    assign push      = valid_reg && !queue_full;
    assign push_item = item_reg;

    always_comb
    begin
        item_next.data     = data_byte;
        item_next.is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
        item_next.is_soh   = (data_byte == SOH_BYTE);
        item_next.digit    = data_byte[3:0];
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* src/fmf_queue.sv */
// Short FIFO of classified bytes between the front and back stages.
module fmf_queue
    import fmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  byte_class_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output byte_class_t pop_item
);

    byte_class_t             store [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg;
    logic [QCNT_W-1:0]       count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/fmf_back.sv */
// Frame parser state machine, max length register and output register.
module fmf_back
    import fmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             max_body_length_we,
    input  logic [LEN_W-1:0] max_body_length,
    input  logic             not_empty,
    input  byte_class_t      pop_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       frame_byte,
    output logic             in_frame,
    output logic             frame_end,
    output logic             frame_abort,
    output logic [LEN_W-1:0] body_length,
    output logic [2:0]       error_code
);

    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_X     = 8'h58;

    function automatic logic [7:0] sync_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd1:    c = CH_EQ;
            3'd2:    c = CH_F;
            3'd3:    c = CH_I;
            3'd4:    c = CH_X;
            default: c = CH_EIGHT;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sum_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CH_ONE;
            2'd1:    c = CH_ZERO;
            default: c = CH_EQ;
        endcase
        return c;
    endfunction

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [MP_W-1:0]   mp_reg;
    logic [MP_W-1:0]   mp_next;
    logic [LEN_W-1:0]  acc_reg;
    logic [LEN_W-1:0]  acc_next;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  rem_next;
    logic [LEN_W-1:0]  max_len_reg;
    logic [LEN_W-1:0]  max_eff;
    logic [LEN_W+3:0]  len_value;

    logic              out_valid_reg;
    logic [7:0]        byte_reg;
    logic              inf_reg;
    logic              fend_reg;
    logic              abort_reg;
    logic [LEN_W-1:0]  blen_reg;
    err_t              err_reg;

    logic              inf;
    logic              fend;
    logic              abort_mark;
    logic [LEN_W-1:0]  blen;
    err_t              err;
    logic              fail;
    logic              restart;
    logic [7:0]        b;

    assign b       = pop_item.data;
    assign pop     = not_empty && (!out_valid_reg || !out_stall);
    assign max_eff = (max_len_reg > LENGTH_LIMIT) ? LENGTH_LIMIT : max_len_reg;
    // acc * 10 + digit
    assign len_value = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {{LEN_W{1'b0}}, pop_item.digit};

    always_comb
    begin
        phase_next = phase_reg;
        mp_next    = mp_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        inf        = 1'b0;
        fend       = 1'b0;
        abort_mark = 1'b0;
        blen       = '0;
        err        = ERR_NONE;
        fail       = 1'b0;
        restart    = 1'b0;

        unique case (phase_reg)
            PH_BEGIN:
            begin
                if (pop_item.is_soh)
                begin
                    inf        = 1'b1;
                    phase_next = PH_TAG9;
                    mp_next    = '0;
                end
                else if (mp_reg >= MP_W'(BEGIN_FIELD_MAX))
                begin
                    fail = 1'b1;
                    err  = ERR_BEGIN_LONG;
                end
                else
                begin
                    inf     = 1'b1;
                    mp_next = mp_reg + MP_W'(1);
                end
            end
            PH_TAG9:
            begin
                if ((mp_reg == MP_W'(0) && b == CH_NINE) || (mp_reg == MP_W'(1) && b == CH_EQ))
                begin
                    inf     = 1'b1;
                    mp_next = mp_reg + MP_W'(1);
                    if (mp_reg == MP_W'(1))
                    begin
                        phase_next = PH_LENGTH;
                        acc_next   = '0;
                    end
                end
                else
                begin
                    fail = 1'b1;
                    err  = ERR_NO_TAG9;
                end
            end
            PH_LENGTH:
            begin
                if (pop_item.is_digit)
                begin
                    if (len_value > {4'b0000, max_eff})
                    begin
                        fail = 1'b1;
                        err  = ERR_BAD_LENGTH;
                    end
                    else
                    begin
                        inf      = 1'b1;
                        acc_next = len_value[LEN_W-1:0];
                    end
                end
                else if (pop_item.is_soh && acc_reg != '0)
                begin
                    inf        = 1'b1;
                    rem_next   = acc_reg;
                    phase_next = PH_BODY;
                end
                else
                begin
                    fail = 1'b1;
                    err  = ERR_BAD_LENGTH;
                end
            end
            PH_BODY:
            begin
                inf = 1'b1;
                if (rem_reg <= LEN_W'(1))
                begin
                    rem_next   = '0;
                    phase_next = PH_TRAILER;
                    mp_next    = '0;
                end
                else
                begin
                    rem_next = rem_reg - LEN_W'(1);
                end
            end
            PH_TRAILER:
            begin
                if (mp_reg < MP_W'(3))
                begin
                    if (b == sum_char(mp_reg[1:0]))
                    begin
                        inf     = 1'b1;
                        mp_next = mp_reg + MP_W'(1);
                    end
                    else
                    begin
                        fail = 1'b1;
                        err  = ERR_NO_TAG10;
                    end
                end
                else if (mp_reg < MP_W'(6))
                begin
                    if (pop_item.is_digit)
                    begin
                        inf     = 1'b1;
                        mp_next = mp_reg + MP_W'(1);
                    end
                    else
                    begin
                        fail = 1'b1;
                        err  = ERR_CHECKSUM_DIGIT;
                    end
                end
                else if (pop_item.is_soh)
                begin
                    inf        = 1'b1;
                    fend       = 1'b1;
                    blen       = acc_reg;
                    phase_next = PH_HUNT;
                    mp_next    = '0;
                    acc_next   = '0;
                    rem_next   = '0;
                end
                else
                begin
                    fail = 1'b1;
                    err  = ERR_NO_FINAL_SOH;
                end
            end
            PH_HUNT:
            begin
                if (mp_reg >= MP_W'(1) && mp_reg < MP_W'(5) && b == sync_char(mp_reg[2:0]))
                begin
                    inf     = 1'b1;
                    mp_next = mp_reg + MP_W'(1);
                    if (mp_reg == MP_W'(4))
                    begin
                        phase_next = PH_BEGIN;
                    end
                end
                else
                begin
                    // broken sync prefix drops the partial candidate
                    abort_mark = (mp_reg != '0);
                    restart    = 1'b1;
                end
            end
            default:
            begin
                restart = 1'b1;
            end
        endcase

        if (fail)
        begin
            abort_mark = 1'b1;
            restart    = 1'b1;
        end

        // hunt restarts on the aborting byte itself
        if (restart)
        begin
            phase_next = PH_HUNT;
            acc_next   = '0;
            rem_next   = '0;
            inf        = (b == CH_EIGHT);
            mp_next    = (b == CH_EIGHT) ? MP_W'(1) : MP_W'(0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            mp_reg        <= '0;
            acc_reg       <= '0;
            rem_reg       <= '0;
            max_len_reg   <= MAX_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (max_body_length_we)
            begin
                max_len_reg <= max_body_length;
            end
            if (pop)
            begin
                phase_reg <= phase_next;
                mp_reg    <= mp_next;
                acc_reg   <= acc_next;
                rem_reg   <= rem_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg  <= b;
            inf_reg   <= inf;
            fend_reg  <= fend;
            abort_reg <= abort_mark;
            blen_reg  <= blen;
            err_reg   <= err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte  = byte_reg;
    assign in_frame    = inf_reg;
    assign frame_end   = fend_reg;
    assign frame_abort = abort_reg;
    assign body_length = blen_reg;
    assign error_code  = err_reg;

endmodule

/* src/fix_message_framer.sv */
// Top level of the FIX message framer: front stage, byte queue and parser back stage.
//
//  channel   signals                                   direction
//  input     in_valid, in_stall, data_byte             beat in
//  config    max_body_length_we, max_body_length       write only
//  output    out_valid, out_stall, frame_byte,         beat out
//            in_frame, frame_end, frame_abort,
//            body_length, error_code
//
// One beat in and one beat out per cycle while out_stall is low; out_valid rises
// once the input beat has passed the classify register, the queue and the output
// register, when the queue is empty.
// The parser state machine advances once per byte, so it sets the rate.
// A four-entry queue lets the front keep taking beats while out_stall is high.
// Reset is asynchronous active low; max_body_length resets to 1048576.
module fix_message_framer
    import fmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             max_body_length_we,
    input  logic [LEN_W-1:0] max_body_length,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       frame_byte,
    output logic             in_frame,
    output logic             frame_end,
    output logic             frame_abort,
    output logic [LEN_W-1:0] body_length,
    output logic [2:0]       error_code
);

    logic        push;
    byte_class_t push_item;
    logic        queue_full;
    logic        pop;
    logic        not_empty;
    byte_class_t pop_item;

    fmf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    fmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_item  (pop_item)
    );

    fmf_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .max_body_length_we (max_body_length_we),
        .max_body_length    (max_body_length),
        .not_empty          (not_empty),
        .pop_item           (pop_item),
        .pop                (pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .frame_byte         (frame_byte),
        .in_frame           (in_frame),
        .frame_end          (frame_end),
        .frame_abort        (frame_abort),
        .body_length        (body_length),
        .error_code         (error_code)
    );

endmodule
